FILE: sv/pfi_pkg.sv
// shared types and codes for the pareto front insertion block
package pfi_pkg;

  localparam int unsigned ValW = 16;

  typedef logic [1:0] outcome_t;

  localparam outcome_t OUT_INSERTED  = 2'd0;
  localparam outcome_t OUT_DOMINATED = 2'd1;
  localparam outcome_t OUT_MERGED    = 2'd2;
  localparam outcome_t OUT_FULL      = 2'd3;

  typedef struct packed {
    logic [ValW-1:0] load_value;
    logic [ValW-1:0] bandwidth_value;
    logic [ValW-1:0] affinity_value;
  } in_item_t;

  typedef struct packed {
    outcome_t   outcome;
    logic [4:0] insert_position;
    logic [5:0] removed_count;
    logic [5:0] front_size;
  } out_item_t;

  // one stored front entry
  typedef struct packed {
    logic [ValW-1:0] load;
    logic [ValW-1:0] bandwidth;
    logic [ValW-1:0] affinity;
  } entry_t;

endpackage

FILE: sv/pareto_front_insert.sv
// two-objective pareto front insertion over ping-pong entry memories
//
// Keeps up to FRONT_DEPTH points in ascending load order. An item is
// accepted at a rising edge with start high and busy low; busy then stays
// high until the result has been shown. Each item gives exactly one result,
// shown on out_item for one cycle with out_valid high; the receiver cannot
// hold it off, so nothing ever waits on the output side.
// One pass reads the n stored entries from the current bank, one entry a
// cycle while the scan does not stall, through a registered read port,
// checking for a match or a dominating entry and writing the compacted
// front into the other bank. Placing the new point stalls the read, as the
// write port then takes the point instead of the entry just read. busy
// drops with the strobe, so the next item can be accepted at the edge that
// ends it. A match or a dominating entry ends the pass early.
// A successful insert swaps the banks; a merge rewrites one entry in place.
// A synchronous reset empties the front; the memories themselves are not cleared.
module pareto_front_insert #(
  parameter int unsigned FRONT_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pfi_pkg::in_item_t  in_item,
  output logic               out_valid,
  output pfi_pkg::out_item_t out_item
);

  localparam int unsigned AW = (FRONT_DEPTH > 1) ? $clog2(FRONT_DEPTH) : 1;
  localparam int unsigned CW = $clog2(FRONT_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(FRONT_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  pfi_pkg::entry_t bank0 [FRONT_DEPTH];
  pfi_pkg::entry_t bank1 [FRONT_DEPTH];

  state_t             state_r, state_nxt;
  logic               cur_r, cur_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  pfi_pkg::in_item_t  pt_r, pt_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [CW-1:0]      rd_idx_r, rd_idx_nxt;
  logic               d_vld_r, d_vld_nxt;
  logic [AW-1:0]      d_idx_r, d_idx_nxt;
  logic [CW-1:0]      w_r, w_nxt;
  logic [CW-1:0]      removed_r, removed_nxt;
  logic               placed_r, placed_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic               out_valid_r, out_valid_nxt;
  pfi_pkg::out_item_t out_r, out_nxt;

  pfi_pkg::entry_t    rdata0_r, rdata1_r, ent;
  logic               rd_en;

  // compaction writes go to the other bank, merges to the current one
  logic               cmp_we, mrg_we;
  logic [AW-1:0]      cmp_addr, mrg_addr;
  pfi_pkg::entry_t    cmp_data, mrg_data;

  logic               w_room, stall, ge_load, eq_pt, dom, swept, last;

  assign ent     = cur_r ? rdata1_r : rdata0_r;
  assign w_room  = (w_r < DEPTH_C);
  assign ge_load = (ent.load >= pt_r.load_value);
  assign eq_pt   = (ent.load == pt_r.load_value) && (ent.bandwidth == pt_r.bandwidth_value);
  assign dom     = (ent.load <= pt_r.load_value) && (ent.bandwidth <= pt_r.bandwidth_value);
  assign swept   = ge_load && (ent.bandwidth >= pt_r.bandwidth_value);
  assign last    = ((CW'(d_idx_r) + CW'(1)) == n_r);
  assign stall   = (state_r == ST_SCAN) && d_vld_r && !placed_r && ge_load && w_room;
  assign rd_en   = (state_r == ST_SCAN) && (rd_idx_r < n_r) && !stall;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    count_nxt     = count_r;
    pt_nxt        = pt_r;
    n_nxt         = n_r;
    rd_idx_nxt    = rd_idx_r;
    d_vld_nxt     = d_vld_r;
    d_idx_nxt     = d_idx_r;
    w_nxt         = w_r;
    removed_nxt   = removed_r;
    placed_nxt    = placed_r;
    pos_nxt       = pos_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    cmp_we        = 1'b0;
    cmp_addr      = w_r[AW-1:0];
    cmp_data      = ent;
    mrg_we        = 1'b0;
    mrg_addr      = d_idx_r;
    mrg_data      = ent;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          pt_nxt      = in_item;
          n_nxt       = count_r;
          rd_idx_nxt  = '0;
          d_vld_nxt   = 1'b0;
          w_nxt       = '0;
          removed_nxt = '0;
          placed_nxt  = 1'b0;
          pos_nxt     = '0;
          state_nxt   = (count_r == '0) ? ST_FIN : ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (rd_en) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
          d_idx_nxt  = rd_idx_r[AW-1:0];
          d_vld_nxt  = 1'b1;
        end else if (!stall) begin
          d_vld_nxt = 1'b0;
        end

        if (stall) begin
          // the point goes in ahead of this entry, which is looked at next cycle
          cmp_we     = 1'b1;
          cmp_data   = '{load: pt_r.load_value, bandwidth: pt_r.bandwidth_value,
                         affinity: pt_r.affinity_value};
          pos_nxt    = w_r[AW-1:0];
          placed_nxt = 1'b1;
          w_nxt      = w_r + CW'(1);
        end else if (d_vld_r) begin
          if (eq_pt) begin
            mrg_we          = 1'b1;
            mrg_data.affinity = (pt_r.affinity_value > ent.affinity) ?
                                pt_r.affinity_value : ent.affinity;
            out_valid_nxt   = 1'b1;
            out_nxt         = '{outcome: pfi_pkg::OUT_MERGED,
                                insert_position: 5'(d_idx_r),
                                removed_count: '0, front_size: 6'(count_r)};
            d_vld_nxt       = 1'b0;
            state_nxt       = ST_IDLE;
          end else if (dom) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{outcome: pfi_pkg::OUT_DOMINATED, insert_position: '0,
                              removed_count: '0, front_size: 6'(count_r)};
            d_vld_nxt     = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            if (swept) begin
              removed_nxt = removed_r + CW'(1);
            end else if (w_room) begin
              cmp_we = 1'b1;
              w_nxt  = w_r + CW'(1);
            end
            if (last) begin
              d_vld_nxt = 1'b0;
              state_nxt = ST_FIN;
            end
          end
        end
      end

      ST_FIN: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        if ((removed_r == '0) && (n_r == DEPTH_C)) begin
          out_nxt = '{outcome: pfi_pkg::OUT_FULL, insert_position: '0,
                      removed_count: '0, front_size: 6'(count_r)};
        end else begin
          // point lies beyond every stored load: append at the tail
          if (!placed_r && w_room) begin
            cmp_we    = 1'b1;
            cmp_data  = '{load: pt_r.load_value, bandwidth: pt_r.bandwidth_value,
                          affinity: pt_r.affinity_value};
            pos_nxt   = w_r[AW-1:0];
            count_nxt = w_r + CW'(1);
          end else begin
            count_nxt = w_r;
          end
          cur_nxt = !cur_r;
          out_nxt = '{outcome: pfi_pkg::OUT_INSERTED,
                      insert_position: 5'(pos_nxt),
                      removed_count: 6'(removed_r), front_size: 6'(count_nxt)};
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= 1'b0;
      count_r     <= '0;
      d_vld_r     <= 1'b0;
      placed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      count_r     <= count_nxt;
      d_vld_r     <= d_vld_nxt;
      placed_r    <= placed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pt_r      <= pt_nxt;
    n_r       <= n_nxt;
    rd_idx_r  <= rd_idx_nxt;
    d_idx_r   <= d_idx_nxt;
    w_r       <= w_nxt;
    removed_r <= removed_nxt;
    pos_r     <= pos_nxt;
    out_r     <= out_nxt;
  end

  // bank 0: one read port for the scan, one write port shared by compaction and merge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata0_r <= bank0[rd_idx_r[AW-1:0]];
    end
    if (cur_r ? cmp_we : mrg_we) begin
      bank0[cur_r ? cmp_addr : mrg_addr] <= cur_r ? cmp_data : mrg_data;
    end
  end

  // bank 1
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata1_r <= bank1[rd_idx_r[AW-1:0]];
    end
    if (cur_r ? mrg_we : cmp_we) begin
      bank1[cur_r ? mrg_addr : cmp_addr] <= cur_r ? mrg_data : cmp_data;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
